// ===== design/sgpa_pkg.sv =====
// ----------------------------------------------------------------------------
// sgpa_pkg
// Shared widths, register codes and the sine table for the grating adder.
// ----------------------------------------------------------------------------
package sgpa_pkg;

  // Field and register widths
  localparam int COORD_W  = 8;
  localparam int PIX_W    = 8;
  localparam int CFG_FRAC = 8;   // fractional bits of the position registers
  localparam int LEVEL_W  = 17;  // offset and amplitude
  localparam int PERIOD_W = 20;
  localparam int PHASE_W  = 21;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 21;

  // Phase divider
  localparam int DIST_W = 22;           // signed coord*256 - phase
  localparam int MAG_W  = 21;           // magnitude of that distance
  localparam int REM_W  = PERIOD_W;     // remainder is always below the period
  localparam int FRAC_W = 16;           // fraction of a turn
  localparam int DIV_LAT = 1 + MAG_W + 1 + FRAC_W;

  // Sine table
  localparam int SINE_LOG   = 10;
  localparam int SINE_DEPTH = 1 << SINE_LOG;
  localparam int SINE_W     = 16;
  localparam int SINE_RND   = 1 << (FRAC_W - SINE_LOG - 1);

  // Wave sum, Q23
  localparam int SUM_FRAC  = 23;
  localparam int OFS_SHIFT = 15;
  localparam int PROD_W    = LEVEL_W + SINE_W;
  localparam int SUM_W     = 35;

  // Register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OFFSET,
    REG_AMPLITUDE,
    REG_PERIOD_X,
    REG_PHASE_X,
    REG_PERIOD_Y,
    REG_PHASE_Y
  } cfg_reg_t;

  // Reset values
  localparam logic signed [LEVEL_W-1:0] OFFSET_RST    = LEVEL_W'(32768);
  localparam logic signed [LEVEL_W-1:0] AMPLITUDE_RST = LEVEL_W'(32768);
  localparam logic [PERIOD_W-1:0]       PERIOD_X_RST  = PERIOD_W'(65536);

  // Q30 constants for the table build
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint          ONE_Q30     = 64'sd1 <<< 30;

  // Reciprocals of the Taylor divisors: exact floor for dividends below 2^RCP_N
  localparam int           RCP_N   = 40;
  localparam logic [127:0] RCP_6   = ((128'd1 << (RCP_N + 3)) + 128'd5) / 128'd6;
  localparam logic [127:0] RCP_20  = ((128'd1 << (RCP_N + 5)) + 128'd19) / 128'd20;
  localparam logic [127:0] RCP_42  = ((128'd1 << (RCP_N + 6)) + 128'd41) / 128'd42;
  localparam logic [127:0] RCP_72  = ((128'd1 << (RCP_N + 7)) + 128'd71) / 128'd72;
  localparam logic [127:0] RCP_110 = ((128'd1 << (RCP_N + 7)) + 128'd109) / 128'd110;

  typedef logic signed [SINE_W-1:0] sine_lut_t [SINE_DEPTH];

  // sin(pi/2 * u), u and result in Q30, Taylor series up to x^11
  function automatic longint quarter_sine(longint u);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          acc;
    logic [127:0]    rcp;
    int              sh;
    x    = (longint'(u) * HALF_PI_Q30) >> 30;
    x2   = (x * x) >> 30;
    term = x;
    acc  = longint'(x);
    for (int k = 1; k <= 5; k++) begin
      term = (term * x2) >> 30;
      // divide by (2k)(2k+1)
      case (k)
        1: begin
          rcp = RCP_6;
          sh  = RCP_N + 3;
        end
        2: begin
          rcp = RCP_20;
          sh  = RCP_N + 5;
        end
        3: begin
          rcp = RCP_42;
          sh  = RCP_N + 6;
        end
        4: begin
          rcp = RCP_72;
          sh  = RCP_N + 7;
        end
        default: begin
          rcp = RCP_110;
          sh  = RCP_N + 7;
        end
      endcase
      term = 64'((128'(term) * rcp) >> sh);
      if (k[0]) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    return (acc < 0) ? 64'sd0 : acc;
  endfunction

  // One Q1.15 entry: sin(2*pi*k/SINE_DEPTH), rounded and limited
  function automatic longint sine_entry(int k);
    longint n4;
    longint q;
    longint r;
    longint u;
    longint s;
    longint v;
    n4 = 4 * longint'(k);
    q  = n4 >>> SINE_LOG;
    r  = n4 & longint'(SINE_DEPTH - 1);
    u  = (r <<< 30) >>> SINE_LOG;
    if (q[0]) begin
      u = ONE_Q30 - u;
    end
    s = quarter_sine(u);
    v = (s + (64'sd1 <<< 14)) >>> 15;
    if (v > 32767) begin
      v = 32767;
    end
    return q[1] ? -v : v;
  endfunction

  function automatic sine_lut_t build_sine_lut();
    sine_lut_t lut;
    for (int k = 0; k < SINE_DEPTH; k++) begin
      lut[k] = SINE_W'(sine_entry(k));
    end
    return lut;
  endfunction

  localparam sine_lut_t SINE_LUT = build_sine_lut();

endpackage

// ===== design/sgpa_term_div.sv =====
// ----------------------------------------------------------------------------
// sgpa_term_div
// Pipelined phase term: fraction of a turn of (coord*256 - phase) / period.
// One restoring step per stage: remainder first, then 16 fraction bits.
// ----------------------------------------------------------------------------
module sgpa_term_div (
  input  logic                                 clk,
  input  logic                                 ce,
  input  logic [sgpa_pkg::COORD_W-1:0]         coord,
  input  logic [sgpa_pkg::PERIOD_W-1:0]        period,
  input  logic signed [sgpa_pkg::PHASE_W-1:0]  phase,
  output logic [sgpa_pkg::FRAC_W-1:0]          frac
);
  import sgpa_pkg::*;

  logic signed [DIST_W-1:0] delta;
  logic [DIST_W-1:0]        delta_neg;
  logic [MAG_W-1:0]         mag;

  logic [MAG_W-1:0] dvd_r  [MAG_W];
  logic [REM_W-1:0] rem_r  [MAG_W+1];
  logic             neg_r  [MAG_W+1];
  logic [REM_W-1:0] frem_r [FRAC_W+1];
  logic [FRAC_W-1:0] q_r   [FRAC_W+1];

  // Distance in 1/256 pixel and its magnitude
  always_comb begin
    delta = $signed({{(DIST_W-COORD_W-CFG_FRAC){1'b0}}, coord, {CFG_FRAC{1'b0}}})
          - $signed({{(DIST_W-PHASE_W){phase[PHASE_W-1]}}, phase});
    delta_neg = -delta;
    mag = delta[DIST_W-1] ? delta_neg[MAG_W-1:0] : delta[MAG_W-1:0];
  end

  // Load stage
  always_ff @(posedge clk) begin
    if (ce) begin
      dvd_r[0] <= mag;
      rem_r[0] <= '0;
      neg_r[0] <= delta[DIST_W-1];
    end
  end

  // Remainder stages, dividend MSB first
  for (genvar s = 1; s <= MAG_W; s++) begin : g_rem
    logic [REM_W:0] trial;
    logic [REM_W:0] diff;
    logic           ge;
    assign trial = {rem_r[s-1], dvd_r[s-1][MAG_W-1]};
    assign diff  = trial - {1'b0, period};
    assign ge    = (trial >= {1'b0, period});

    always_ff @(posedge clk) begin
      if (ce) begin
        rem_r[s] <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
        neg_r[s] <= neg_r[s-1];
      end
    end

    if (s < MAG_W) begin : g_shift
      always_ff @(posedge clk) begin
        if (ce) begin
          dvd_r[s] <= {dvd_r[s-1][MAG_W-2:0], 1'b0};
        end
      end
    end
  end

  // Floor modulo: a negative distance with a remainder folds back
  always_ff @(posedge clk) begin
    if (ce) begin
      frem_r[0] <= (neg_r[MAG_W] && (rem_r[MAG_W] != '0)) ? period - rem_r[MAG_W]
                                                            : rem_r[MAG_W];
      q_r[0]    <= '0;
    end
  end

  // Fraction stages: one quotient bit each
  for (genvar f = 1; f <= FRAC_W; f++) begin : g_frac
    logic [REM_W:0] trial;
    logic [REM_W:0] diff;
    logic           ge;
    assign trial = {frem_r[f-1], 1'b0};
    assign diff  = trial - {1'b0, period};
    assign ge    = (trial >= {1'b0, period});

    always_ff @(posedge clk) begin
      if (ce) begin
        frem_r[f] <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
        q_r[f]    <= {q_r[f-1][FRAC_W-2:0], ge};
      end
    end
  end

  // A zero period contributes nothing
  assign frac = (period == '0) ? '0 : q_r[FRAC_W];

endmodule

// ===== design/sine_grating_pixel_adder.sv =====
// ----------------------------------------------------------------------------
// sine_grating_pixel_adder
// Adds a sinusoidal grating to a pixel stream, one pixel per request.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake            Payload
//  in_      in   in_tvalid/in_tready  tdata: col[7:0] row[15:8] pixel_in[23:16]
//  out_     out  out_tvalid/out_tready tdata: pixel_out[7:0]
//  cfg_     in   cfg_valid/cfg_ready  cfg_index register, cfg_data value
//
//  One request per cycle sustained while the skid is empty.
//  The depth is set by the two phase dividers, one restoring step per stage
//  (a load stage, 21 remainder steps, a fold stage, 16 fraction steps), then
//  index, sine table read, multiply and sum/clamp stages.
//  rst_n (synchronous) clears valid bits and loads the register defaults.
//  Output stalls are absorbed by a one-entry skid; in_tready drops only while
//  the skid holds a result.
// ----------------------------------------------------------------------------
module sine_grating_pixel_adder (
  input  logic                                clk,
  input  logic                                rst_n,
  // in_tdata: col, row, pixel_in (lowest bits first)
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [3*sgpa_pkg::PIX_W-1:0]        in_tdata,
  // out_tdata: pixel_out
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [sgpa_pkg::PIX_W-1:0]          out_tdata,
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sgpa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sgpa_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import sgpa_pkg::*;

  // Configuration registers
  logic signed [LEVEL_W-1:0] offset_r;
  logic signed [LEVEL_W-1:0] amplitude_r;
  logic [PERIOD_W-1:0]       period_x_r;
  logic signed [PHASE_W-1:0] phase_x_r;
  logic [PERIOD_W-1:0]       period_y_r;
  logic signed [PHASE_W-1:0] phase_y_r;

  // Pipeline
  logic                      ce;
  logic                      v_r   [DIV_LAT];
  logic [PIX_W-1:0]          pix_r [DIV_LAT];
  logic [FRAC_W-1:0]         frac_x;
  logic [FRAC_W-1:0]         frac_y;
  logic [FRAC_W-1:0]         ph;
  logic [FRAC_W:0]           ph_rnd;

  logic                      idx_v_r;
  logic [PIX_W-1:0]          idx_pix_r;
  logic [SINE_LOG-1:0]       idx_r;

  logic                      sin_v_r;
  logic [PIX_W-1:0]          sin_pix_r;
  logic signed [SINE_W-1:0]  sine_r;

  logic                      mul_v_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [SUM_W-1:0]   base_r;
  logic signed [SUM_W-1:0]   base;

  logic signed [SUM_W-1:0]   sum;
  logic [PIX_W-1:0]          res;
  logic                      fin_v_r;
  logic [PIX_W-1:0]          fin_d_r;

  // Output register and skid
  logic                      out_v_r, out_v_nxt;
  logic [PIX_W-1:0]          out_d_r, out_d_nxt;
  logic                      skid_v_r, skid_v_nxt;
  logic [PIX_W-1:0]          skid_d_r, skid_d_nxt;

  // ---------------- configuration ----------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r    <= OFFSET_RST;
      amplitude_r <= AMPLITUDE_RST;
      period_x_r  <= PERIOD_X_RST;
      phase_x_r   <= '0;
      period_y_r  <= '0;
      phase_y_r   <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_OFFSET:    offset_r    <= cfg_data[LEVEL_W-1:0];
        REG_AMPLITUDE: amplitude_r <= cfg_data[LEVEL_W-1:0];
        REG_PERIOD_X:  period_x_r  <= cfg_data[PERIOD_W-1:0];
        REG_PHASE_X:   phase_x_r   <= cfg_data[PHASE_W-1:0];
        REG_PERIOD_Y:  period_y_r  <= cfg_data[PERIOD_W-1:0];
        REG_PHASE_Y:   phase_y_r   <= cfg_data[PHASE_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- pipeline advance ----------------
  assign ce        = !skid_v_r;
  assign in_tready = ce;

  // Phase terms
  sgpa_term_div u_div_x (
    .clk    (clk),
    .ce     (ce),
    .coord  (in_tdata[COORD_W-1:0]),
    .period (period_x_r),
    .phase  (phase_x_r),
    .frac   (frac_x)
  );

  sgpa_term_div u_div_y (
    .clk    (clk),
    .ce     (ce),
    .coord  (in_tdata[2*COORD_W-1:COORD_W]),
    .period (period_y_r),
    .phase  (phase_y_r),
    .frac   (frac_y)
  );

  // Valid bits and pixel follow the divider depth
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_LAT; i++) begin
        v_r[i] <= 1'b0;
      end
    end else if (ce) begin
      v_r[0] <= in_tvalid;
      for (int i = 1; i < DIV_LAT; i++) begin
        v_r[i] <= v_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      pix_r[0] <= in_tdata[3*PIX_W-1:2*PIX_W];
      for (int i = 1; i < DIV_LAT; i++) begin
        pix_r[i] <= pix_r[i-1];
      end
    end
  end

  // Table index: phase scaled to the table, rounded half up, wrapped
  always_comb begin
    ph     = frac_x + frac_y;
    ph_rnd = {1'b0, ph} + (FRAC_W+1)'(SINE_RND);
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      idx_r     <= ph_rnd[FRAC_W-SINE_LOG +: SINE_LOG];
      idx_pix_r <= pix_r[DIV_LAT-1];
    end
  end

  // Sine table read
  always_ff @(posedge clk) begin
    if (ce) begin
      sine_r    <= SINE_LUT[idx_r];
      sin_pix_r <= idx_pix_r;
    end
  end

  // Amplitude product and the pixel/offset base, Q23
  assign base = $signed({{(SUM_W-PIX_W-SUM_FRAC){1'b0}}, sin_pix_r, {SUM_FRAC{1'b0}}})
              + $signed({{(SUM_W-LEVEL_W-OFS_SHIFT){offset_r[LEVEL_W-1]}}, offset_r,
                         {OFS_SHIFT{1'b0}}});

  always_ff @(posedge clk) begin
    if (ce) begin
      prod_r <= amplitude_r * sine_r;
      base_r <= base;
    end
  end

  // Sum, truncate and clamp to 0..255
  always_comb begin
    sum = base_r + $signed({{(SUM_W-PROD_W){prod_r[PROD_W-1]}}, prod_r});
    if (sum[SUM_W-1] || (sum == '0)) begin
      res = '0;
    end else if (|sum[SUM_W-2:SUM_FRAC+PIX_W]) begin
      res = '1;
    end else begin
      res = sum[SUM_FRAC +: PIX_W];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      fin_d_r <= res;
    end
  end

  // Valid bits of the tail stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_v_r <= 1'b0;
      sin_v_r <= 1'b0;
      mul_v_r <= 1'b0;
      fin_v_r <= 1'b0;
    end else if (ce) begin
      idx_v_r <= v_r[DIV_LAT-1];
      sin_v_r <= idx_v_r;
      mul_v_r <= sin_v_r;
      fin_v_r <= mul_v_r;
    end
  end

  // ---------------- output register and skid ----------------
  always_comb begin
    out_v_nxt  = out_v_r;
    out_d_nxt  = out_d_r;
    skid_v_nxt = skid_v_r;
    skid_d_nxt = skid_d_r;
    if (!out_v_r || out_tready) begin
      if (skid_v_r) begin
        out_v_nxt  = 1'b1;
        out_d_nxt  = skid_d_r;
        skid_v_nxt = 1'b0;
      end else begin
        out_v_nxt = fin_v_r;
        out_d_nxt = fin_d_r;
      end
    end else if (ce && fin_v_r) begin
      skid_v_nxt = 1'b1;
      skid_d_nxt = fin_d_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_d_r  <= out_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sine grating pixel adder. A queue-fed driver
// streams pixel requests; every accepted request is run through a local
// grating calculation and the expected grey level is queued. The monitor
// checks each output against the oldest expected level. Registers are
// reprogrammed between phases while the pipeline is empty. Both sides idle
// at random.
// ----------------------------------------------------------------------------
module tb_top;
  import sgpa_pkg::*;

  // Unmapped register indexes, writes must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

  // pi/2 and 1.0 in Q30 for the sine table
  localparam longint unsigned QTR_TURN_RAD_Q30 = 64'd1686629713;
  localparam longint unsigned UNIT_Q30         = 64'd1 << 30;

  localparam int PHASE_ITEMS = 50;
  localparam int PHASES      = 9;

  // tdata layout: col lowest, then row, then pixel_in
  typedef struct packed {
    logic [PIX_W-1:0]   pixel_in;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } pixel_req_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [3*PIX_W-1:0]    in_tdata = '0;     // col, row, pixel_in
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [PIX_W-1:0]      out_tdata;          // pixel_out
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Local copy of the register file
  logic signed [LEVEL_W-1:0] cur_offset    = OFFSET_RST;
  logic signed [LEVEL_W-1:0] cur_amplitude = AMPLITUDE_RST;
  logic [PERIOD_W-1:0]       cur_period_x  = PERIOD_X_RST;
  logic signed [PHASE_W-1:0] cur_phase_x   = '0;
  logic [PERIOD_W-1:0]       cur_period_y  = '0;
  logic signed [PHASE_W-1:0] cur_phase_y   = '0;

  int         sine_q15 [SINE_DEPTH];
  pixel_req_t pixel_req_q[$];
  logic [7:0] pixel_expect_q[$];
  logic [7:0] want_pixel;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  int         err_count = 0;

  sine_grating_pixel_adder u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #4 clk = ~clk;

  // Q1.15 sine of k/SINE_DEPTH turns, Taylor series to x^11 on a quarter wave
  function automatic int sine_sample(int k);
    longint          quad;
    longint          rem;
    longint unsigned u;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          acc;
    longint          v;
    int              n;
    quad = longint'(4 * k) / SINE_DEPTH;
    rem  = longint'(4 * k) % SINE_DEPTH;
    u    = (longint'(rem) << 30) / SINE_DEPTH;
    if (quad[0]) begin
      u = UNIT_Q30 - u;
    end
    x    = (u * QTR_TURN_RAD_Q30) >> 30;
    x2   = (x * x) >> 30;
    term = x;
    acc  = longint'(x);
    for (n = 1; n <= 5; n++) begin
      term = (term * x2) >> 30;
      term = term / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    v = (acc + 64'sd16384) >>> 15;
    if (v > 32767) begin
      v = 32767;
    end
    return int'(quad[1] ? -v : v);
  endfunction

  // Fraction of a turn (16 bits) of (coord*256 - shift) / period, zero period -> 0
  function automatic logic [15:0] turn_fraction(logic [7:0] coord,
                                                logic [PERIOD_W-1:0] period,
                                                logic signed [PHASE_W-1:0] shift);
    longint p;
    longint d;
    longint r;
    p = longint'(period);
    if (p == 0) begin
      return '0;
    end
    d = longint'(coord) * 256 - longint'(shift);
    r = d % p;
    if (r < 0) begin
      r = r + p;
    end
    return 16'((r << 16) / p);
  endfunction

  // Grey level after adding the grating to one pixel
  function automatic logic [7:0] grating_pixel(pixel_req_t req);
    logic [15:0] turn;
    int          lut_idx;
    longint      acc;
    turn = turn_fraction(req.col, cur_period_x, cur_phase_x)
         + turn_fraction(req.row, cur_period_y, cur_phase_y);
    lut_idx = ((int'(turn) * SINE_DEPTH + 32768) >> 16) % SINE_DEPTH;
    acc = (longint'(req.pixel_in) <<< 23)
        + (longint'(cur_offset) <<< 15)
        + longint'(cur_amplitude) * longint'(sine_q15[lut_idx]);
    if (acc <= 0) begin
      return '0;
    end
    if ((acc >>> 23) > 255) begin
      return 8'd255;
    end
    return 8'(acc >>> 23);
  endfunction

  // Driver: one request per free slot unless idling
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) begin
        pixel_expect_q.push_back(grating_pixel(pixel_req_t'(in_tdata)));
      end
      if (pixel_req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_tdata  <= pixel_req_q.pop_front();
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: compare each output with the oldest expected level
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (pixel_expect_q.size() == 0) begin
          $display("%0t: unexpected pixel_out, expected none, got %0d", $time, out_tdata);
          err_count++;
        end else begin
          want_pixel = pixel_expect_q.pop_front();
          if (out_tdata !== want_pixel) begin
            $display("%0t: pixel_out mismatch, expected %0d, got %0d",
                     $time, want_pixel, out_tdata);
            err_count++;
          end
        end
      end
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Wait until no request is pending and every expected level has arrived
  task automatic wait_idle();
    do begin
      @(negedge clk);
    end while (pixel_req_q.size() != 0 || in_tvalid || pixel_expect_q.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_OFFSET:    cur_offset    = val[LEVEL_W-1:0];
      REG_AMPLITUDE: cur_amplitude = val[LEVEL_W-1:0];
      REG_PERIOD_X:  cur_period_x  = val[PERIOD_W-1:0];
      REG_PHASE_X:   cur_phase_x   = val[PHASE_W-1:0];
      REG_PERIOD_Y:  cur_period_y  = val[PERIOD_W-1:0];
      REG_PHASE_Y:   cur_phase_y   = val[PHASE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic queue_pixel(input int col, input int row, input int pix);
    pixel_req_t req;
    req.col      = 8'(col);
    req.row      = 8'(row);
    req.pixel_in = 8'(pix);
    pixel_req_q.push_back(req);
  endtask

  // Random level: extremes, full range or a moderate grey range
  function automatic logic [CFG_DATA_W-1:0] rand_level();
    case ($urandom_range(3))
      0:       return $urandom_range(1) ? CFG_DATA_W'(-65536) : CFG_DATA_W'(65535);
      1:       return CFG_DATA_W'($urandom());
      default: return CFG_DATA_W'(int'($urandom_range(98304)) - 32768);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_period();
    case ($urandom_range(5))
      0:       return '0;
      1:       return CFG_DATA_W'($urandom_range(1, 255));
      2:       return CFG_DATA_W'(1048575);
      3:       return CFG_DATA_W'($urandom_range(0, 1048575));
      default: return CFG_DATA_W'($urandom_range(256, 16384));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_shift();
    if ($urandom_range(1)) begin
      return CFG_DATA_W'($urandom());
    end
    return CFG_DATA_W'(int'($urandom_range(131072)) - 65536);
  endfunction

  initial begin
    for (int k = 0; k < SINE_DEPTH; k++) begin
      sine_q15[k] = sine_sample(k);
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 15;
    recv_idle_pct = 64;

    // Defaults: horizontal grating, vertical term off by zero period
    wait_idle();
    queue_pixel(0, 0, 0);
    queue_pixel(64, 17, 0);
    queue_pixel(128, 200, 128);
    queue_pixel(192, 255, 0);
    queue_pixel(255, 0, 255);
    queue_pixel(0, 255, 255);

    // Most negative offset: sums go below zero
    wait_idle();
    write_reg(REG_OFFSET, CFG_DATA_W'(-65536));
    write_reg(REG_AMPLITUDE, CFG_DATA_W'(65535));
    write_reg(REG_PERIOD_X, '0);
    write_reg(REG_PERIOD_Y, CFG_DATA_W'(1));
    write_reg(REG_PHASE_Y, CFG_DATA_W'(-1048576));
    wait_idle();
    queue_pixel(0, 0, 255);
    queue_pixel(255, 255, 0);
    queue_pixel(37, 99, 200);

    // Largest offset and periods: saturation; unmapped writes are dropped
    wait_idle();
    write_reg(REG_OFFSET, CFG_DATA_W'(65535));
    write_reg(REG_AMPLITUDE, CFG_DATA_W'(-65536));
    write_reg(REG_PERIOD_X, CFG_DATA_W'(1048575));
    write_reg(REG_PHASE_X, CFG_DATA_W'(1048575));
    write_reg(REG_PERIOD_Y, CFG_DATA_W'(1048575));
    write_reg(REG_PHASE_Y, CFG_DATA_W'(1048575));
    write_reg(REG_UNMAPPED_LO, '1);
    write_reg(REG_UNMAPPED_HI, CFG_DATA_W'(21'h0AAAAA));
    wait_idle();
    queue_pixel(0, 0, 255);
    queue_pixel(255, 255, 255);
    queue_pixel(255, 0, 0);
    queue_pixel(0, 255, 128);

    // Random phases: fresh registers, then a burst of random pixels
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      case (ph / 3)
        0: begin
          send_idle_pct = 15;
          recv_idle_pct = 64;
        end
        1: begin
          send_idle_pct = 64;
          recv_idle_pct = 15;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      write_reg(REG_OFFSET, rand_level());
      write_reg(REG_AMPLITUDE, rand_level());
      write_reg(REG_PERIOD_X, rand_period());
      write_reg(REG_PHASE_X, rand_shift());
      write_reg(REG_PERIOD_Y, rand_period());
      write_reg(REG_PHASE_Y, rand_shift());
      if ($urandom_range(3) == 0) begin
        write_reg($urandom_range(1) ? REG_UNMAPPED_LO : REG_UNMAPPED_HI,
                  CFG_DATA_W'($urandom()));
      end
      wait_idle();
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        queue_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255));
      end
    end

    // Drain, then watch for stray outputs
    wait_idle();
    repeat (100) @(posedge clk);
    if (err_count == 0 && pixel_expect_q.size() == 0) begin
      $display("** sine_grating_pixel_adder: PASSED **");
    end else begin
      $display("** sine_grating_pixel_adder: FAILED **");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(2_000_000);
    $display("** sine_grating_pixel_adder: FAILED **");
    $finish;
  end

endmodule

// ===== files.f =====
design/sgpa_pkg.sv
design/sgpa_term_div.sv
design/sine_grating_pixel_adder.sv
verif/tb_top.sv
